// ----- src/dtta_pkg.sv -----
// ----------------------------------------------------------------------------
// dtta_pkg
// Shared widths, codes and types of the door travel time averager.
// ----------------------------------------------------------------------------
package dtta_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int TIME_W         = 16;
    localparam int COUNT_W        = 10;
    localparam int CONFIRM_W      = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 10;
    localparam int PROD_W         = TIME_W + COUNT_W;
    localparam int DIVIDEND_W     = PROD_W + 1;
    localparam int DIVISOR_W      = COUNT_W + 1;
    localparam int STEP_W         = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT = 2'd1;

    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET    = 8'd4;
    localparam logic [COUNT_W-1:0]   MAX_WEIGHT_RESET = 10'd1000;

    // Door status codes
    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_MOVING = 2'd1;
    localparam logic [1:0] ST_OPEN   = 2'd2;

    // New-sample flag codes
    localparam logic [1:0] FLAG_NONE  = 2'd0;
    localparam logic [1:0] FLAG_OPEN  = 2'd1;
    localparam logic [1:0] FLAG_CLOSE = 2'd2;

    typedef enum logic [2:0] {
        PH_READY,
        PH_MOVING,
        PH_STILL_MOVING,
        PH_OPEN,
        PH_CLOSED
    } door_phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_FOLD,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        FU_IDLE,
        FU_MUL,
        FU_DIV,
        FU_DONE
    } fold_state_t;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  sample;
    } fold_req_t;

    typedef struct packed {
        logic               done;
        logic [TIME_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
    } fold_rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0] open_time;
        logic [TIME_W-1:0] close_time;
        logic [TIME_W-1:0] mean_open_time;
        logic [TIME_W-1:0] mean_close_time;
        logic [1:0]        new_sample;
    } dtta_result_t;

endpackage

// ----- src/dtta_fold.sv -----
// ----------------------------------------------------------------------------
// dtta_fold
// Serial mean update: (mean*count + sample) / (count + 1), one bit per cycle.
// ----------------------------------------------------------------------------
module dtta_fold (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dtta_pkg::COUNT_W-1:0]   max_weight,
    input  dtta_pkg::fold_req_t            req,
    output dtta_pkg::fold_rsp_t            rsp
);
    import dtta_pkg::*;

    fold_state_t           state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TIME_W-1:0]     mcand_reg, mcand_next;
    logic [TIME_W:0]       hi_reg, hi_next;
    logic [COUNT_W-1:0]    lo_reg, lo_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [COUNT_W-1:0]    wcount_reg, wcount_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]     quo_reg, quo_next;

    logic [TIME_W:0]       hi_sum;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W+1:0]  trial;
    logic                  trial_ge;
    logic [DIVISOR_W-1:0]  count_inc;
    logic                  last_step;

    assign count_inc = {1'b0, req.count} + DIVISOR_W'(1);
    assign last_step = (step_reg == STEP_W'(1));
    assign hi_sum    = lo_reg[0] ? (hi_reg + {1'b0, mcand_reg}) : hi_reg;
    // product register after this step; the upper half starts at the sample,
    // so after the last step it holds mean*count + sample
    assign dividend  = {1'b0, hi_sum, lo_reg[COUNT_W-1:1]};
    assign trial     = {1'b0, rem_reg, quo_reg[TIME_W-1]} - {2'b00, divisor_reg};
    assign trial_ge  = ~trial[DIVISOR_W+1];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FU_IDLE: if (req.start) state_next = FU_MUL;
            FU_MUL:  if (last_step) state_next = FU_DIV;
            FU_DIV:  if (last_step) state_next = FU_DONE;
            FU_DONE: state_next = FU_IDLE;
            default: state_next = FU_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        step_next    = step_reg;
        mcand_next   = mcand_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        divisor_next = divisor_reg;
        wcount_next  = wcount_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        unique case (state_reg)
            FU_IDLE:
            begin
                if (req.start)
                begin
                    step_next    = STEP_W'(COUNT_W);
                    mcand_next   = req.mean;
                    hi_next      = {1'b0, req.sample};
                    lo_next      = req.count;
                    divisor_next = count_inc;
                    wcount_next  = (count_inc > {1'b0, max_weight}) ? max_weight
                                                                    : count_inc[COUNT_W-1:0];
                end
            end
            FU_MUL:
            begin
                // add multiplicand on a set multiplier bit, shift product right
                {hi_next, lo_next} = dividend;
                step_next = step_reg - STEP_W'(1);
                if (last_step)
                begin
                    // quotient fits 16 bits, so the top part is below the divisor
                    step_next = STEP_W'(TIME_W);
                    rem_next  = dividend[DIVIDEND_W-1:TIME_W];
                    quo_next  = dividend[TIME_W-1:0];
                end
            end
            FU_DIV:
            begin
                rem_next  = trial_ge ? trial[DIVISOR_W-1:0]
                                     : {rem_reg[DIVISOR_W-2:0], quo_reg[TIME_W-1]};
                quo_next  = {quo_reg[TIME_W-2:0], trial_ge};
                step_next = step_reg - STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FU_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        divisor_reg <= divisor_next;
        wcount_reg  <= wcount_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    // Outputs
    always_comb
    begin
        rsp.done  = (state_reg == FU_DONE);
        rsp.mean  = quo_reg;
        rsp.count = wcount_reg;
    end

endmodule

// ----- src/dtta_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtta_ctrl
// Door phase tracking, item sequencing and the stored times and means.
// ----------------------------------------------------------------------------
module dtta_ctrl #(
    parameter int TICK_WIDTH = dtta_pkg::TICK_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      door_status,
    input  logic                            run_mode,
    input  logic [TICK_WIDTH-1:0]           tick_now,
    input  logic [dtta_pkg::CONFIRM_W-1:0]  confirm_samples,
    output dtta_pkg::fold_req_t             fold_req,
    input  dtta_pkg::fold_rsp_t             fold_rsp,
    output logic                            res_valid,
    input  logic                            res_take,
    output dtta_pkg::dtta_result_t          result
);
    import dtta_pkg::*;

    seq_state_t            seq_reg, seq_next;
    door_phase_t           phase_reg, phase_next;
    logic [CONFIRM_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [1:0]            status_reg;
    logic                  run_reg;
    logic [TIME_W-1:0]     tick_reg;
    logic [1:0]            flag_reg;
    logic [COUNT_W-1:0]    open_cnt_reg, close_cnt_reg;
    logic [TIME_W-1:0]     open_mean_reg, close_mean_reg;
    logic [TIME_W-1:0]     open_last_reg, close_last_reg;

    logic                  rec;
    logic                  rec_open;
    logic                  match;
    logic [1:0]            target;
    logic [CONFIRM_W-1:0]  cnt_inc;
    logic                  accept;

    assign accept  = in_valid && in_ready;
    assign cnt_inc = cnt_reg + CONFIRM_W'(1);

    // Door phase update for the held word
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        elapsed_next = elapsed_reg;
        rec          = 1'b0;
        rec_open     = (phase_reg == PH_OPEN);
        target       = (phase_reg == PH_OPEN) ? ST_OPEN
                     : (phase_reg == PH_CLOSED) ? ST_CLOSED : ST_MOVING;
        match        = (status_reg == target);
        case (phase_reg)
            PH_MOVING, PH_OPEN, PH_CLOSED:
            begin
                if (match)
                begin
                    cnt_next = cnt_inc;
                end
                if (cnt_next == confirm_samples)
                begin
                    if (phase_reg == PH_MOVING)
                    begin
                        phase_next = PH_STILL_MOVING;
                    end
                    else
                    begin
                        phase_next = PH_READY;
                        rec        = 1'b1;
                    end
                end
                if (!match)
                begin
                    phase_next = PH_READY;
                end
            end
            PH_STILL_MOVING:
            begin
                if (status_reg == ST_OPEN || status_reg == ST_CLOSED)
                begin
                    phase_next   = (status_reg == ST_OPEN) ? PH_OPEN : PH_CLOSED;
                    elapsed_next = tick_reg - start_reg;
                    cnt_next     = '0;
                end
            end
            default:
            begin
                phase_next   = PH_READY;
                elapsed_next = '0;
                if (status_reg == ST_MOVING)
                begin
                    phase_next = PH_MOVING;
                    start_next = tick_reg;
                    cnt_next   = '0;
                end
            end
        endcase
        if (!run_reg)
        begin
            phase_next   = phase_reg;
            cnt_next     = cnt_reg;
            start_next   = start_reg;
            elapsed_next = elapsed_reg;
            rec          = 1'b0;
        end
    end

    // Sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE: if (in_valid) seq_next = SEQ_EVAL;
            SEQ_EVAL: seq_next = rec ? SEQ_FOLD : SEQ_DONE;
            SEQ_FOLD: if (fold_rsp.done) seq_next = SEQ_DONE;
            SEQ_DONE: if (res_take) seq_next = SEQ_IDLE;
            default:  seq_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready       = (seq_reg == SEQ_IDLE);
        res_valid      = (seq_reg == SEQ_DONE);
        fold_req.start = (seq_reg == SEQ_EVAL) && rec;
        fold_req.mean  = rec_open ? open_mean_reg : close_mean_reg;
        fold_req.count = rec_open ? open_cnt_reg : close_cnt_reg;
        fold_req.sample = elapsed_reg;
    end

    always_comb
    begin
        result.open_time       = open_last_reg;
        result.close_time      = close_last_reg;
        result.mean_open_time  = open_mean_reg;
        result.mean_close_time = close_mean_reg;
        result.new_sample      = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= SEQ_IDLE;
            phase_reg      <= PH_READY;
            cnt_reg        <= '0;
            start_reg      <= '0;
            elapsed_reg    <= '0;
            flag_reg       <= FLAG_NONE;
            open_cnt_reg   <= '0;
            close_cnt_reg  <= '0;
            open_mean_reg  <= '0;
            close_mean_reg <= '0;
            open_last_reg  <= '0;
            close_last_reg <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (seq_reg == SEQ_EVAL)
            begin
                phase_reg   <= phase_next;
                cnt_reg     <= cnt_next;
                start_reg   <= start_next;
                elapsed_reg <= elapsed_next;
                flag_reg    <= FLAG_NONE;
                if (rec)
                begin
                    if (rec_open)
                    begin
                        open_last_reg <= elapsed_reg;
                        flag_reg      <= FLAG_OPEN;
                    end
                    else
                    begin
                        close_last_reg <= elapsed_reg;
                        flag_reg       <= FLAG_CLOSE;
                    end
                end
            end
            if (seq_reg == SEQ_FOLD && fold_rsp.done)
            begin
                if (flag_reg == FLAG_OPEN)
                begin
                    open_mean_reg <= fold_rsp.mean;
                    open_cnt_reg  <= fold_rsp.count;
                end
                else
                begin
                    close_mean_reg <= fold_rsp.mean;
                    close_cnt_reg  <= fold_rsp.count;
                end
            end
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= door_status;
            run_reg    <= run_mode;
            tick_reg   <= tick_now[TIME_W-1:0];
        end
    end

endmodule

// ----- src/door_travel_time_averager_top.sv -----
// ----------------------------------------------------------------------------
// door_travel_time_averager_top
// Door travel time measurement with confirmed end states and running means.
// ----------------------------------------------------------------------------
// Each input word carries the door status, a run-mode bit and the current
// tick. One result word comes back for every input word, in order, holding
// the last open and close travel times, their running means and a flag that
// tells whether this word recorded a new open or close time. A word that
// records nothing goes through evaluation and handoff; a word that records
// a time also goes through the serial mean unit: a shift-add multiply (one
// count bit per cycle, seeded with the new time), then a restoring division
// (one quotient bit per cycle), before handoff. The next word is accepted
// only after handoff. A result that cannot leave because the output
// register is full and out_ready is low holds the input for as long.
// A finished result sits in the output register while the next word is
// accepted and worked on. Configuration writes are always taken; write them
// only while no word is in flight. Register 0 is confirm_samples, register 1
// max_weight.
// ----------------------------------------------------------------------------
module door_travel_time_averager_top #(
    parameter int TICK_WIDTH = dtta_pkg::TICK_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        door_status,
    input  logic                              run_mode,
    input  logic [TICK_WIDTH-1:0]             tick_now,
    // result words
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dtta_pkg::TIME_W-1:0]       open_time,
    output logic [dtta_pkg::TIME_W-1:0]       close_time,
    output logic [dtta_pkg::TIME_W-1:0]       mean_open_time,
    output logic [dtta_pkg::TIME_W-1:0]       mean_close_time,
    output logic [1:0]                        new_sample,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dtta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dtta_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dtta_pkg::*;

    logic [CONFIRM_W-1:0] confirm_reg;
    logic [COUNT_W-1:0]   max_weight_reg;
    logic                 out_valid_reg;
    dtta_result_t         out_reg;
    dtta_result_t         result;
    fold_req_t            fold_req;
    fold_rsp_t            fold_rsp;
    logic                 res_valid;
    logic                 slot_free;

    // Configuration registers: writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg    <= CONFIRM_RESET;
            max_weight_reg <= MAX_WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CONFIRM:    confirm_reg    <= cfg_data[CONFIRM_W-1:0];
                CFG_MAX_WEIGHT: max_weight_reg <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Phase tracking and sequencing
    dtta_ctrl #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .door_status     (door_status),
        .run_mode        (run_mode),
        .tick_now        (tick_now),
        .confirm_samples (confirm_reg),
        .fold_req        (fold_req),
        .fold_rsp        (fold_rsp),
        .res_valid       (res_valid),
        .res_take        (slot_free),
        .result          (result)
    );

    // Serial mean update
    dtta_fold u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_weight (max_weight_reg),
        .req        (fold_req),
        .rsp        (fold_rsp)
    );

    // Output register: load a finished result when the slot is empty or
    // being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign open_time       = out_reg.open_time;
    assign close_time      = out_reg.close_time;
    assign mean_open_time  = out_reg.mean_open_time;
    assign mean_close_time = out_reg.mean_close_time;
    assign new_sample      = out_reg.new_sample;

endmodule

// ----- test/door_travel_checker.sv -----
// ----------------------------------------------------------------------------
// door_travel_checker
// Predicts every result word of the door travel time averager and checks it.
// ----------------------------------------------------------------------------
// Watches the input, result and configuration channels at the rising edge.
// Each accepted input word advances a private copy of the door phase logic
// and queues the result word it should produce. Each accepted result word is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module door_travel_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      door_status,
    input  logic                            run_mode,
    input  logic [dtta_pkg::TICK_WIDTH_DEF-1:0] tick_now,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [dtta_pkg::TIME_W-1:0]     open_time,
    input  logic [dtta_pkg::TIME_W-1:0]     close_time,
    input  logic [dtta_pkg::TIME_W-1:0]     mean_open_time,
    input  logic [dtta_pkg::TIME_W-1:0]     mean_close_time,
    input  logic [1:0]                      new_sample,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dtta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtta_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              words_in,
    output int                              opens_recorded,
    output int                              closes_recorded
);
    timeunit 1ns;
    timeprecision 1ps;

    import dtta_pkg::*;

    door_phase_t                  phase;
    logic [CONFIRM_W-1:0]         confirm_cnt;
    logic [CONFIRM_W-1:0]         confirm_cfg;
    logic [COUNT_W-1:0]           weight_cfg;
    logic [COUNT_W-1:0]           open_weight;
    logic [COUNT_W-1:0]           close_weight;
    logic [TICK_WIDTH_DEF-1:0]    start_tick;
    logic [TIME_W-1:0]            travel;
    logic [TIME_W-1:0]            open_last;
    logic [TIME_W-1:0]            close_last;
    logic [TIME_W-1:0]            open_mean;
    logic [TIME_W-1:0]            close_mean;
    dtta_result_t                 travel_q[$];

    // Returns {new mean, new weight}.
    function automatic logic [TIME_W+COUNT_W-1:0] fold_mean(
        input logic [TIME_W-1:0]  mean,
        input logic [COUNT_W-1:0] weight,
        input logic [TIME_W-1:0]  sample,
        input logic [COUNT_W-1:0] cap
    );
        logic [31:0] mean32;
        logic [31:0] weight32;
        logic [31:0] total;
        logic [31:0] quotient;
        logic [31:0] next_weight;
        mean32      = 32'(mean);
        weight32    = 32'(weight);
        total       = mean32 * weight32 + 32'(sample);
        quotient    = total / (weight32 + 32'd1);
        next_weight = weight32 + 32'd1;
        if (next_weight > 32'(cap))
            next_weight = 32'(cap);
        return {quotient[TIME_W-1:0], next_weight[COUNT_W-1:0]};
    endfunction

    task automatic step_door(
        input  logic [1:0]                status,
        input  logic                      run,
        input  logic [TICK_WIDTH_DEF-1:0] tick,
        output dtta_result_t              res
    );
        logic [1:0]                flag;
        logic [1:0]                target;
        logic                      hit;
        logic                      to_open;
        logic [TICK_WIDTH_DEF-1:0] diff;
        flag = FLAG_NONE;
        if (run)
        begin
            case (phase)
                PH_MOVING:
                begin
                    if (status == ST_MOVING)
                        confirm_cnt = confirm_cnt + CONFIRM_W'(1);
                    if (confirm_cnt == confirm_cfg)
                        phase = PH_STILL_MOVING;
                    if (status != ST_MOVING)
                        phase = PH_READY;
                end
                PH_STILL_MOVING:
                begin
                    // driving or moving keeps the phase
                    if (status == ST_OPEN || status == ST_CLOSED)
                    begin
                        phase       = (status == ST_OPEN) ? PH_OPEN : PH_CLOSED;
                        diff        = tick - start_tick;
                        travel      = diff[TIME_W-1:0];
                        confirm_cnt = '0;
                    end
                end
                PH_OPEN, PH_CLOSED:
                begin
                    to_open = (phase == PH_OPEN);
                    target  = to_open ? ST_OPEN : ST_CLOSED;
                    hit     = 1'b0;
                    // count, then compare, then drop on a mismatch
                    if (status == target)
                        confirm_cnt = confirm_cnt + CONFIRM_W'(1);
                    if (confirm_cnt == confirm_cfg)
                    begin
                        hit   = 1'b1;
                        phase = PH_READY;
                    end
                    if (status != target)
                        phase = PH_READY;
                    if (hit && to_open)
                    begin
                        open_last = travel;
                        {open_mean, open_weight} =
                            fold_mean(open_mean, open_weight, open_last, weight_cfg);
                        flag = FLAG_OPEN;
                    end
                    else if (hit)
                    begin
                        close_last = travel;
                        {close_mean, close_weight} =
                            fold_mean(close_mean, close_weight, close_last, weight_cfg);
                        flag = FLAG_CLOSE;
                    end
                end
                default:
                begin
                    phase  = PH_READY;
                    travel = '0;
                    if (status == ST_MOVING)
                    begin
                        phase       = PH_MOVING;
                        start_tick  = tick;
                        confirm_cnt = '0;
                    end
                end
            endcase
        end
        res.open_time       = open_last;
        res.close_time      = close_last;
        res.mean_open_time  = open_mean;
        res.mean_close_time = close_mean;
        res.new_sample      = flag;
    endtask

    function automatic int field_differs(
        input string             field,
        input logic [TIME_W-1:0] want_v,
        input logic [TIME_W-1:0] got_v
    );
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dtta_result_t want;
        if (!rst_n)
        begin
            phase           = PH_READY;
            confirm_cnt     = '0;
            confirm_cfg     = CONFIRM_RESET;
            weight_cfg      = MAX_WEIGHT_RESET;
            open_weight     = '0;
            close_weight    = '0;
            start_tick      = '0;
            travel          = '0;
            open_last       = '0;
            close_last      = '0;
            open_mean       = '0;
            close_mean      = '0;
            travel_q.delete();
            fail_count      = 0;
            pending         = 0;
            words_in        = 0;
            opens_recorded  = 0;
            closes_recorded = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CONFIRM)
                    confirm_cfg = cfg_data[CONFIRM_W-1:0];
                else if (cfg_index == CFG_MAX_WEIGHT)
                    weight_cfg = cfg_data[COUNT_W-1:0];
            end
            // a result word always belongs to an earlier input word: pop first
            if (out_valid && out_ready)
            begin
                if (travel_q.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = travel_q.pop_front();
                    fail_count += field_differs("open_time", want.open_time, open_time);
                    fail_count += field_differs("close_time", want.close_time, close_time);
                    fail_count += field_differs("mean_open_time", want.mean_open_time,
                                                mean_open_time);
                    fail_count += field_differs("mean_close_time", want.mean_close_time,
                                                mean_close_time);
                    fail_count += field_differs("new_sample", TIME_W'(want.new_sample),
                                                TIME_W'(new_sample));
                end
            end
            if (in_valid && in_ready)
            begin
                step_door(door_status, run_mode, tick_now, want);
                travel_q.push_back(want);
                words_in++;
                if (want.new_sample == FLAG_OPEN)
                    opens_recorded++;
                else if (want.new_sample == FLAG_CLOSE)
                    closes_recorded++;
            end
            pending = travel_q.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the door travel time averager.
// ----------------------------------------------------------------------------
// A short directed run walks the door through a full open measurement across
// a tick wrap, then through the zero-confirm and zero-weight corners. Random
// phases follow, each under its own register setting, made mostly of full
// door cycles (confirmed motion, coasting, confirmed end state) with random
// tick spacing, some cut short, plus bursts of random words and of words
// outside run mode. Both channels idle at random. A separate checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtta_pkg::*;

    // Door status "cabin driving" has no code in the package.
    localparam logic [1:0] ST_DRIVING = 2'd3;

    // Slowest legal word: a long input gap, a word that records a time and a
    // long result stall. Allow many times that with no handshake.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            door_status;
    logic                  run_mode;
    logic [TICK_WIDTH_DEF-1:0] tick_now;
    logic                  out_valid;
    logic                  out_ready;
    logic [TIME_W-1:0]     open_time;
    logic [TIME_W-1:0]     close_time;
    logic [TIME_W-1:0]     mean_open_time;
    logic [TIME_W-1:0]     mean_close_time;
    logic [1:0]            new_sample;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    pending;
    int                    words_in;
    int                    opens_recorded;
    int                    closes_recorded;

    int                    words_sent;
    int                    settings_used;
    int                    stall_cycles;
    int                    out_hold;
    bit                    in_gaps_on;
    bit                    out_stalls_on;
    logic [TICK_WIDTH_DEF-1:0] tick_base;

    door_travel_time_averager_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .door_status     (door_status),
        .run_mode        (run_mode),
        .tick_now        (tick_now),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .open_time       (open_time),
        .close_time      (close_time),
        .mean_open_time  (mean_open_time),
        .mean_close_time (mean_close_time),
        .new_sample      (new_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    door_travel_checker u_travel_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .door_status     (door_status),
        .run_mode        (run_mode),
        .tick_now        (tick_now),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .open_time       (open_time),
        .close_time      (close_time),
        .mean_open_time  (mean_open_time),
        .mean_close_time (mean_close_time),
        .new_sample      (new_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .words_in        (words_in),
        .opens_recorded  (opens_recorded),
        .closes_recorded (closes_recorded)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Tick spacing between samples: usually short, sometimes past 16 bits.
    function automatic int unsigned tick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 400);
        if (r < 90)
            return $urandom_range(401, 5000);
        if (r < 98)
            return $urandom_range(5001, 90000);
        return 0;
    endfunction

    function automatic logic [1:0] pick_other(input logic [1:0] avoid);
        logic [1:0] pick;
        do
            pick = 2'($urandom_range(0, 3));
        while (pick == avoid);
        return pick;
    endfunction

    // Result side: hold ready low for random stretches, with quiet spells.
    initial
    begin
        out_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (out_hold > 0)
            begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 29) == 0)
                    out_stalls_on = !out_stalls_on;
                if (out_stalls_on && $urandom_range(0, 2) == 0)
                    out_hold = pick_gap();
            end
        end
    end

    // Watchdog: end the run if no channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Present one input word and hold it until accepted. Valid stays high
    // on return so a following word can go back to back.
    task automatic drive_word(
        input logic [1:0]                status,
        input logic                      run,
        input logic [TICK_WIDTH_DEF-1:0] tick
    );
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_gaps_on = !in_gaps_on;
        gap = in_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        door_status <= status;
        run_mode    <= run;
        tick_now    <= tick;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Live sample in run mode; now and then slip an ignored word in first.
    task automatic send_live(input logic [1:0] status);
        if ($urandom_range(0, 29) == 0)
            drive_word(2'($urandom_range(0, 3)), 1'b0, $urandom);
        tick_base += tick_step();
        drive_word(status, 1'b1, tick_base);
    endtask

    // Drop valid and wait until every result word has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One door cycle: confirmed motion, coasting, confirmed end state.
    // Either half may be cut short to exercise the abort paths.
    task automatic door_cycle(input int need);
        int         n;
        bit         cut;
        logic [1:0] end_status;
        if ($urandom_range(0, 9) == 0)
            tick_base = $urandom;
        else if ($urandom_range(0, 19) == 0)
            tick_base = '1 - $urandom_range(0, 3000);
        if ($urandom_range(0, 1) == 1)
            send_live(pick_other(ST_MOVING));
        cut = ($urandom_range(0, 6) == 0);
        n = cut ? $urandom_range(1, need) : need + 1;
        repeat (n) send_live(ST_MOVING);
        if (cut)
        begin
            send_live(pick_other(ST_MOVING));
            return;
        end
        repeat ($urandom_range(0, 3))
            send_live($urandom_range(0, 1) ? ST_MOVING : ST_DRIVING);
        end_status = $urandom_range(0, 1) ? ST_OPEN : ST_CLOSED;
        cut = ($urandom_range(0, 6) == 0);
        n = cut ? $urandom_range(1, need) : need + 1 + $urandom_range(0, 1);
        repeat (n) send_live(end_status);
        if (cut)
            send_live(pick_other(end_status));
    endtask

    // Apply a register setting, then mix door cycles with noise.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] confirm_data,
                             input logic [CFG_DATA_W-1:0] weight_data,
                             input int                    words);
        int need;
        int first;
        int pick;
        drain();
        write_reg(CFG_CONFIRM, confirm_data);
        write_reg(CFG_MAX_WEIGHT, weight_data);
        settings_used++;
        need  = (confirm_data[CONFIRM_W-1:0] == 0) ? 256
                                                   : int'(confirm_data[CONFIRM_W-1:0]);
        first = words_sent;
        while (words_sent - first < words)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                door_cycle(need);
            else if (pick < 9)
                repeat ($urandom_range(1, 6))
                    drive_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               $urandom);
            else
                repeat ($urandom_range(1, 4))
                    drive_word(2'($urandom_range(0, 3)), 1'b0, $urandom);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        door_status   = ST_CLOSED;
        run_mode      = 1'b0;
        tick_now      = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_CONFIRM;
        cfg_data      = '0;
        words_sent    = 0;
        settings_used = 1;
        stall_cycles  = 0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        tick_base     = $urandom;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setting (confirm 4): ignored word, driving while ready, then a
        // full open measurement whose start sits just below the tick wrap.
        drive_word(ST_MOVING, 1'b0, 32'hFFFF_FFFF);
        drive_word(ST_DRIVING, 1'b1, 32'h0000_0005);
        drive_word(ST_MOVING, 1'b1, 32'hFFFF_FF00);
        drive_word(ST_MOVING, 1'b1, 32'hFFFF_FF40);
        drive_word(ST_MOVING, 1'b1, 32'hFFFF_FF80);
        drive_word(ST_MOVING, 1'b1, 32'hFFFF_FFC0);
        drive_word(ST_MOVING, 1'b1, 32'h0000_0010);
        // cabin driving keeps confirmed motion; a word outside run mode is ignored
        drive_word(ST_DRIVING, 1'b1, 32'h0000_0020);
        drive_word(ST_CLOSED, 1'b0, 32'h0000_0000);
        // elapsed crosses the wrap and exceeds 16 bits
        drive_word(ST_OPEN, 1'b1, 32'h0001_2345);
        repeat (4) drive_word(ST_OPEN, 1'b1, 32'h0001_3000);

        // Confirm of one (upper data bits set and dropped): reach confirmed motion.
        drain();
        write_reg(CFG_CONFIRM, 10'h301);
        settings_used++;
        drive_word(ST_MOVING, 1'b1, 32'h0000_0000);
        drive_word(ST_MOVING, 1'b1, 32'h0000_0001);

        // Zero confirm and zero weight: a mismatching word records the close
        // time, and the mean follows the newest time.
        drain();
        write_reg(CFG_CONFIRM, 10'h300);
        write_reg(CFG_MAX_WEIGHT, 10'd0);
        settings_used++;
        drive_word(ST_CLOSED, 1'b1, 32'h0000_FFFF);
        drive_word(ST_OPEN, 1'b1, 32'h0001_0000);
        drive_word(ST_MOVING, 1'b1, 32'h0000_0007);
        drive_word(ST_CLOSED, 1'b1, 32'h0000_0009);

        // Random phases; the long-confirm phase covers the largest setting.
        run_phase(10'h001, 10'd1, 90);
        run_phase(10'h002, 10'h3FF, 90);
        run_phase(10'h0FF, 10'h3FF, 300);
        run_phase(10'h003, 10'd4, 90);
        run_phase(10'h104, 10'd1000, 80);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d input words under %0d register settings", words_in,
                 settings_used);
        $display("recorded %0d open and %0d close travel times", opens_recorded,
                 closes_recorded);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
